// ===== rtl/core/ptsc_pkg.sv =====
`default_nettype none

package ptsc_pkg;

   localparam int unsigned CLK_W     = 32;
   localparam int unsigned FREQ_W    = 32;
   localparam int unsigned DUTY_W    = 18;
   localparam int unsigned DUTYC_W   = 17;
   localparam int unsigned REG16_W   = 16;
   localparam int unsigned CHAN_W    = 2;
   localparam int unsigned DIV_CNT_W = 5;
   localparam int unsigned MUL_CNT_W = 4;

   localparam logic [CLK_W-1:0]   SYSCLK_RESET = 32'd72000000;
   localparam logic [DUTYC_W-1:0] DUTY_ONE     = 17'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_DIV2,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic half;    // quotient known to fit 16 bits: 16 steps
   } div_ctrl_type;

   typedef struct packed {
      logic done;    // one-cycle pulse, quotient valid
      logic zero;    // quotient is zero
   } div_stat_type;

   // Q2.16 duty clamped to 0..1.0
   function automatic logic [DUTYC_W-1:0] clamp_duty(input logic [DUTY_W-1:0] raw);
      logic [DUTYC_W-1:0] v;
      v = raw[DUTYC_W-1:0];
      if (raw[DUTY_W-1]) begin
         return '0;
      end else if (v > DUTY_ONE) begin
         return DUTY_ONE;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pwm_timer_setting_calculator_unit.sv =====
// PWM timer setting calculator. Each request beat carries a carrier frequency and a Q2.16
// duty for one of four lines; the response beat gives prescaler, auto-reload and compare
// for a 16-bit timer clocked at the csr_wdata clock rate (reset 72 MHz). One request is
// worked at a time, through the shared bit-serial divider (32 steps for ticks = clock /
// carrier, 16 steps for ticks / (prescaler + 1)) and a 16-step shift-add multiplier for
// compare. A zero carrier answers with line_off set and all settings zero. A finished
// response waits in an output register, so the next request is taken while it is still
// unread.
`default_nettype none

module pwm_timer_setting_calculator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,   // system_clock_hz
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [55:0] req_tdata,   // carrier_hz[31:0], duty_fraction[49:32], zero pad
   input  wire logic [1:0]  req_tuser,   // channel[1:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // prescaler[15:0], auto_reload[31:16], compare[47:32]
   output      logic [2:0]  rsp_tuser    // channel_out[1:0], line_off[2]
);

   ptsc_pkg::state_type               state_ff, state_in;
   logic [ptsc_pkg::CLK_W-1:0]        sysclk_ff;
   logic [ptsc_pkg::CHAN_W-1:0]       chan_ff;
   logic                              off_ff;
   logic [ptsc_pkg::DUTYC_W-1:0]      duty_ff;
   logic [ptsc_pkg::REG16_W-1:0]      psc_ff;
   logic [ptsc_pkg::REG16_W-1:0]      reload_ff;
   logic [ptsc_pkg::DUTYC_W-1:0]      mul_hi_ff;
   logic [ptsc_pkg::REG16_W-1:0]      mul_lo_ff;
   logic [ptsc_pkg::MUL_CNT_W-1:0]    mul_cnt_ff;
   logic                              rsp_valid_ff;
   logic [47:0]                       rsp_data_ff;
   logic [2:0]                        rsp_user_ff;

   logic [ptsc_pkg::FREQ_W-1:0]       carrier;
   logic                              accept;
   logic                              load_psc;
   logic                              load_mul;
   logic                              mul_step;
   logic                              out_load;
   ptsc_pkg::div_ctrl_type            div_ctrl;
   ptsc_pkg::div_stat_type            div_stat;
   logic [ptsc_pkg::CLK_W-1:0]        div_dividend;
   logic [ptsc_pkg::CLK_W-1:0]        div_divisor;
   logic [ptsc_pkg::CLK_W-1:0]        div_quo;
   logic [ptsc_pkg::CLK_W-1:0]        ticks;
   logic [ptsc_pkg::REG16_W:0]        psc_plus1;
   logic [ptsc_pkg::REG16_W-1:0]      quot16;
   logic [ptsc_pkg::REG16_W-1:0]      reload;
   logic [ptsc_pkg::DUTYC_W:0]        mul_sum;
   logic [ptsc_pkg::REG16_W-1:0]      cmp;

   assign carrier = req_tdata[31:0];

   // datapath helpers
   always_comb begin
      ticks     = div_stat.zero ? ptsc_pkg::CLK_W'(1) : div_quo;
      psc_plus1 = {1'b0, ticks[31:16]} + 17'd1;
      quot16    = (div_quo[15:0] == '0) ? 16'd1 : div_quo[15:0];
      reload    = quot16 - 16'd1;
      mul_sum   = {1'b0, mul_hi_ff} + (mul_lo_ff[0] ? {1'b0, duty_ff} : '0);
      // round half up: bit 15 of the product's low half
      cmp       = mul_hi_ff[15:0] + {15'd0, mul_lo_ff[15]};
   end

   // next state and control
   always_comb begin
      state_in      = state_ff;
      accept        = 1'b0;
      load_psc      = 1'b0;
      load_mul      = 1'b0;
      mul_step      = 1'b0;
      out_load      = 1'b0;
      req_tready    = 1'b0;
      div_ctrl      = '0;
      div_dividend  = sysclk_ff;
      div_divisor   = carrier;
      case (state_ff)
         ptsc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               accept = 1'b1;
               if (carrier == '0) begin
                  state_in = ptsc_pkg::ST_DONE;
               end else begin
                  div_ctrl.start = 1'b1;
                  state_in       = ptsc_pkg::ST_DIV1;
               end
            end
         end
         ptsc_pkg::ST_DIV1: begin
            div_dividend = ticks;
            div_divisor  = {15'd0, psc_plus1};
            if (div_stat.done) begin
               load_psc       = 1'b1;
               div_ctrl.start = 1'b1;
               div_ctrl.half  = 1'b1;
               state_in       = ptsc_pkg::ST_DIV2;
            end
         end
         ptsc_pkg::ST_DIV2: begin
            if (div_stat.done) begin
               load_mul = 1'b1;
               state_in = ptsc_pkg::ST_MUL;
            end
         end
         ptsc_pkg::ST_MUL: begin
            mul_step = 1'b1;
            if (mul_cnt_ff == '0) begin
               state_in = ptsc_pkg::ST_DONE;
            end
         end
         ptsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ptsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptsc_pkg::ST_IDLE;
         end
      endcase
   end

   ptsc_serdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptsc_pkg::ST_IDLE;
         sysclk_ff    <= ptsc_pkg::SYSCLK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            sysclk_ff <= csr_wdata;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff <= req_tuser;
         duty_ff <= ptsc_pkg::clamp_duty(req_tdata[49:32]);
         off_ff  <= (carrier == '0);
         // zeros serve the line-off answer
         psc_ff    <= '0;
         reload_ff <= '0;
         mul_hi_ff <= '0;
         mul_lo_ff <= '0;
      end
      if (load_psc) begin
         psc_ff <= ticks[31:16];
      end
      if (load_mul) begin
         reload_ff  <= reload;
         mul_hi_ff  <= '0;
         mul_lo_ff  <= reload;
         mul_cnt_ff <= ptsc_pkg::MUL_CNT_W'(ptsc_pkg::REG16_W - 1);
      end
      if (mul_step) begin
         mul_hi_ff  <= mul_sum[ptsc_pkg::DUTYC_W:1];
         mul_lo_ff  <= {mul_sum[0], mul_lo_ff[ptsc_pkg::REG16_W-1:1]};
         mul_cnt_ff <= mul_cnt_ff - ptsc_pkg::MUL_CNT_W'(1);
      end
      if (out_load) begin
         rsp_data_ff <= {cmp, reload_ff, psc_ff};
         rsp_user_ff <= {off_ff, chan_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ptsc_serdiv.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ptsc_serdiv (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptsc_pkg::div_ctrl_type        ctrl,
   input  wire logic [ptsc_pkg::CLK_W-1:0]    dividend,
   input  wire logic [ptsc_pkg::CLK_W-1:0]    divisor,
   output      ptsc_pkg::div_stat_type        stat,
   output      logic [ptsc_pkg::CLK_W-1:0]    quotient
);

   logic [ptsc_pkg::CLK_W-1:0]     rem_ff, rem_in;
   logic [ptsc_pkg::CLK_W-1:0]     quo_ff, quo_in;
   logic [ptsc_pkg::CLK_W-1:0]     dsr_ff;
   logic [ptsc_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [ptsc_pkg::CLK_W+1:0]     diff;
   logic                           fits;

   always_comb begin
      diff   = {1'b0, rem_ff, quo_ff[ptsc_pkg::CLK_W-1]} - {2'b00, dsr_ff};
      fits   = !diff[ptsc_pkg::CLK_W+1];
      rem_in = fits ? diff[ptsc_pkg::CLK_W-1:0]
                    : {rem_ff[ptsc_pkg::CLK_W-2:0], quo_ff[ptsc_pkg::CLK_W-1]};
      quo_in = {quo_ff[ptsc_pkg::CLK_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ctrl.half ? ptsc_pkg::DIV_CNT_W'(ptsc_pkg::REG16_W - 1)
                                 : ptsc_pkg::DIV_CNT_W'(ptsc_pkg::CLK_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - ptsc_pkg::DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         dsr_ff <= divisor;
         if (ctrl.half) begin
            // high half already below the divisor: start mid-way
            rem_ff <= {16'd0, dividend[31:16]};
            quo_ff <= {dividend[15:0], 16'd0};
         end else begin
            rem_ff <= '0;
            quo_ff <= dividend;
         end
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign stat.done = done_ff;
   assign stat.zero = (quo_ff == '0);
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ptsc_checker.sv =====
`default_nettype none

module ptsc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        csr_we,
   input wire logic [31:0] csr_wdata,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [55:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one request in flight: ready drops after a request beat
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !$rose(rsp_tvalid))
      else $error("request taken while another is in flight");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == 48'd0)
      else $error("line off with nonzero settings");

   a_cmp_le_arr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:32] <= rsp_tdata[31:16])
      else $error("compare above auto-reload");

endmodule

bind pwm_timer_setting_calculator_unit ptsc_checker u_ptsc_checker (.*);

`default_nettype wire

// ===== dv/pwm_timer_setting_checker.sv =====
`default_nettype none

module pwm_timer_setting_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,   // system_clock_hz
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,   // carrier_hz[31:0], duty_fraction[49:32], zero pad
   input  wire logic [1:0]  req_tuser,   // channel[1:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,   // prescaler[15:0], auto_reload[31:16], compare[47:32]
   input  wire logic [2:0]  rsp_tuser,   // channel_out[1:0], line_off[2]
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 40;
   localparam logic [16:0] DUTY_FULL = 17'd65536;

   typedef struct packed {
      logic [1:0]  channel;
      logic        line_off;
      logic [15:0] prescaler;
      logic [15:0] auto_reload;
      logic [15:0] compare;
   } timer_setting_type;

   timer_setting_type settings_q[$];
   logic [31:0]       sysclk_hz;

   function automatic timer_setting_type calc_timer_setting(
      input logic [31:0] sysclk,
      input logic [1:0]  chan,
      input logic [31:0] carrier,
      input logic [17:0] duty_raw
   );
      timer_setting_type res;
      logic [16:0]    duty;
      logic [31:0]    ticks;
      logic [31:0]    quot;
      logic [15:0]    psc;
      logic [15:0]    reload;
      logic [63:0]    prod;
      res = '0;
      res.channel = chan;
      if (carrier == '0) begin
         res.line_off = 1'b1;
         return res;
      end
      // negative duty -> 0, above 1.0 -> 1.0
      if (duty_raw[17]) begin
         duty = '0;
      end else if (duty_raw[16:0] > DUTY_FULL) begin
         duty = DUTY_FULL;
      end else begin
         duty = duty_raw[16:0];
      end
      ticks = sysclk / carrier;
      if (ticks == '0) begin
         ticks = 32'd1;
      end
      psc  = ticks[31:16];
      quot = ticks / ({16'b0, psc} + 32'd1);
      if (quot == '0) begin
         quot = 32'd1;
      end else if (quot > 32'hFFFF) begin
         quot = 32'hFFFF;
      end
      reload = quot[15:0] - 16'd1;
      prod   = 64'(duty) * 64'(reload) + 64'd32768;
      res.prescaler   = psc;
      res.auto_reload = reload;
      res.compare     = (prod[63:16] > 48'hFFFF) ? 16'hFFFF : prod[31:16];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (fail_count < PRINT_CAP) begin
         $display("%0t mismatch: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
      end
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin : mon
      timer_setting_type want;
      timer_setting_type got;
      if (reset) begin
         sysclk_hz = ptsc_pkg::SYSCLK_RESET;
         settings_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[1:0], rsp_tuser[2], rsp_tdata[15:0], rsp_tdata[31:16],
                   rsp_tdata[47:32]};
            if (settings_q.size() == 0) begin
               report_mismatch("response beat with nothing pending", '0, 32'(got.compare));
            end else begin
               want = settings_q.pop_front();
               if (got.channel != want.channel)
                  report_mismatch("channel_out", 32'(want.channel), 32'(got.channel));
               if (got.line_off != want.line_off)
                  report_mismatch("line_off", 32'(want.line_off), 32'(got.line_off));
               if (got.prescaler != want.prescaler)
                  report_mismatch("prescaler", 32'(want.prescaler), 32'(got.prescaler));
               if (got.auto_reload != want.auto_reload)
                  report_mismatch("auto_reload", 32'(want.auto_reload), 32'(got.auto_reload));
               if (got.compare != want.compare)
                  report_mismatch("compare", 32'(want.compare), 32'(got.compare));
            end
         end
         if (req_tvalid && req_tready) begin
            settings_q.push_back(calc_timer_setting(sysclk_hz, req_tuser, req_tdata[31:0],
                                                    req_tdata[49:32]));
         end
         if (csr_we) begin
            sysclk_hz = csr_wdata;
         end
      end
      pending_count <= settings_q.size();
   end

endmodule

`default_nettype wire

// ===== dv/pwm_timer_setting_calculator_unit_tb.sv =====
`default_nettype none

module pwm_timer_setting_calculator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NUM_PHASES      = 8;
   localparam int          ITEMS_PER_PHASE = 165;
   localparam int          DRAIN_CYCLES    = 100;
   localparam int unsigned LIMIT_CYCLES    = 1000000;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_PERIODIC
   } ready_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int             fail_count;
   int             pending_count;
   int unsigned    cycle_cnt = 0;
   int unsigned    burst_left = 0;
   ready_mode_type rdy_mode = RDY_ALWAYS;
   int unsigned    rdy_left = 0;

   pwm_timer_setting_calculator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pwm_timer_setting_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // response side backpressure, ready mode changed at random intervals
   always @(posedge clock) begin
      if (rdy_left == 0) begin
         rdy_mode <= ready_mode_type'($urandom_range(0, 3));
         rdy_left <= $urandom_range(20, 400);
      end else begin
         rdy_left <= rdy_left - 1;
      end
      case (rdy_mode)
         RDY_ALWAYS:   rsp_tready <= 1'b1;
         RDY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RDY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
         RDY_PERIODIC: rsp_tready <= ((cycle_cnt % 7) < 4);
      endcase
   end

   function automatic logic [31:0] pick_carrier(input logic [31:0] sysclk);
      int unsigned sel;
      logic [31:0] ticks;
      logic [31:0] carrier;
      sel = $urandom_range(0, 99);
      if (sel < 4) return '0;
      if (sel < 20) return $urandom();
      if (sel < 35) return $urandom_range(1, 2000);
      if (sel < 60) begin
         // land near the points where the prescaler steps
         case ($urandom_range(0, 3))
            0: ticks = 32'd65535 + $urandom_range(0, 2);
            1: ticks = 32'd131071 + $urandom_range(0, 2);
            2: ticks = ({16'b0, 16'($urandom_range(1, 65535))} << 16)
                       + $urandom_range(0, 2) - 1;
            default: ticks = 32'hFFFF_FFFF - $urandom_range(0, 2);
         endcase
      end else begin
         ticks = $urandom() >> $urandom_range(0, 31);
      end
      if (ticks == '0) ticks = 32'd1;
      carrier = sysclk / ticks;
      return (carrier == '0) ? 32'd1 : carrier;
   endfunction

   function automatic logic [17:0] pick_duty();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) return 18'($urandom());
      if (sel < 16) begin
         case ($urandom_range(0, 6))
            0: return 18'h20000;
            1: return 18'h3FFFF;
            2: return 18'h10000;
            3: return 18'h10001;
            4: return 18'h1FFFF;
            5: return 18'h08000;
            default: return 18'h00000;
         endcase
      end
      return 18'($urandom_range(0, 65536));
   endfunction

   task automatic push_req(input logic [1:0] chan, input logic [31:0] carrier,
                           input logic [17:0] duty);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, duty, carrier};
      req_tuser  <= chan;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left = burst_left - 1;
   endtask

   task automatic drain_pending();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_sysclk(input logic [31:0] value);
      drain_pending();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [31:0] sysclk;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: sysclk = ptsc_pkg::SYSCLK_RESET;
            1: sysclk = 32'hFFFF_FFFF;
            2: sysclk = 32'd1;
            3: sysclk = 32'd0;
            4: sysclk = 32'd65536000;
            5: sysclk = 32'd16000000;
            default: sysclk = $urandom();
         endcase
         write_sysclk(sysclk);
         if (phase == 0) begin
            // line off, any duty
            push_req(2'd0, 32'd0, 18'h08000);
            push_req(2'd3, 32'd0, 18'h3FFFF);
            // largest tick count, then carriers on both sides of the prescaler step
            push_req(2'd1, 32'd1, 18'h00000);
            push_req(2'd2, 32'd1, 18'h10000);
            push_req(2'd3, 32'd1098, 18'h0FFFF);
            push_req(2'd0, 32'd1099, 18'h00001);
            push_req(2'd1, 32'd1000, 18'h08000);
            push_req(2'd2, 32'd20000, 18'h07FFF);
            // negative and over-range duty
            push_req(2'd0, 32'd20000, 18'h20000);
            push_req(2'd1, 32'd20000, 18'h3FFFF);
            push_req(2'd2, 32'd20000, 18'h10001);
            push_req(2'd3, 32'd20000, 18'h1FFFF);
            // one tick per period, two ticks with a half-way compare
            push_req(2'd0, 32'd72000000, 18'h08000);
            push_req(2'd1, 32'd36000000, 18'h08000);
            // carrier above the clock
            push_req(2'd2, 32'hFFFF_FFFF, 18'h1FFFF);
            push_req(2'd3, 32'd72000001, 18'h10000);
            push_req(2'd0, 32'hAAAA_5555, 18'h2AAAA);
            push_req(2'd3, 32'h5555_AAAA, 18'h15555);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            push_req(2'($urandom_range(0, 3)), pick_carrier(sysclk), pick_duty());
         end
      end

      drain_pending();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
